FILE: hw/rtl/cabp_pkg.sv
// Shared types, register indexes and byte-lane helpers for the clipped alpha blend pixel block.
`default_nettype none

package cabp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegChannelLayout = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPickMode      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegClipEnable    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegClipLeft      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegClipTop       = 3'd4;
  localparam logic [CfgIdxW-1:0] RegClipWidth     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegClipHeight    = 3'd6;

  localparam logic [8:0] LayoutReset = 9'd228;
  localparam logic [7:0] ByteMax     = 8'hff;

  // What the last stage does with a beat.
  typedef enum logic [1:0] {
    OpKeep,
    OpClear,
    OpBlend,
    OpCopy
  } op_e;

  // Read one byte of a packed word from a two-bit slot number.
  function automatic logic [7:0] get_slot(logic [31:0] word, logic [1:0] slot);
    logic [7:0] b;
    case (slot)
      2'd0:    b = word[7:0];
      2'd1:    b = word[15:8];
      2'd2:    b = word[23:16];
      default: b = word[31:24];
    endcase
    return b;
  endfunction

  // Place one byte into a word at a two-bit slot number.
  function automatic logic [31:0] put_slot(logic [7:0] v, logic [1:0] slot);
    return {24'd0, v} << {slot, 3'b000};
  endfunction

  // Pack four channels by layout; shared slots OR together, alpha only if present.
  function automatic logic [31:0] pack_px(logic [8:0] lay, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b, logic [7:0] a);
    logic [31:0] w;
    w = put_slot(r, lay[1:0]) | put_slot(g, lay[3:2]) | put_slot(b, lay[5:4]);
    if (lay[8]) begin
      w = w | put_slot(a, lay[7:6]);
    end
    return w;
  endfunction

  // Exact floor(p / 255) for p up to 255*255.
  function automatic logic [7:0] div255(logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/clipped_alpha_blend_pixel.sv
// Top level of the clipped alpha blend pixel block: clip test, unpack, blend and repack.
`default_nettype none

// Pixel write processor. Each input beat carries a coordinate, a source RGBA
// color (or a null flag), a blend request and the current destination word; each
// beat yields exactly one result beat with write_done and the new pixel word.
// The coordinate is tested against the clip rectangle (far edges exclusive) when
// clip_enable is set. Inside the clip, a null color writes zero; with blending
// requested and pick mode off, each color channel becomes (a*s+(255-a)*d)/255
// truncated, destination alpha is kept, and the word is repacked by the channel
// layout; otherwise the source color is packed. Outside the clip the destination
// word passes through unchanged. Beats pass a clip/unpack stage, a multiply
// stage and a divide/pack output stage; one beat is taken every cycle while
// the output is not stalled. A stall is absorbed by empty stages first, so the
// input stalls only when all three stages hold beats and the output is stalled.
// Configuration writes are always ready and must only be issued while idle.
module clipped_alpha_blend_pixel (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cabp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cabp_pkg::CfgDataW-1:0] cfg_data_i,
  // input beat
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [15:0]            pixel_x_i,
  input  wire logic signed [15:0]            pixel_y_i,
  input  wire logic [7:0]                    src_red_i,
  input  wire logic [7:0]                    src_green_i,
  input  wire logic [7:0]                    src_blue_i,
  input  wire logic [7:0]                    src_alpha_i,
  input  wire logic                          color_null_i,
  input  wire logic                          blend_enable_i,
  input  wire logic [31:0]                   dest_word_i,
  // result beat
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               write_done_o,
  output logic [31:0]                        pixel_out_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [8:0]         layout_q;
  logic               pick_q;
  logic               clip_en_q;
  logic signed [15:0] clip_left_q;
  logic signed [15:0] clip_top_q;
  logic [14:0]        clip_w_q;
  logic [14:0]        clip_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q    <= cabp_pkg::LayoutReset;
      pick_q      <= 1'b0;
      clip_en_q   <= 1'b0;
      clip_left_q <= '0;
      clip_top_q  <= '0;
      clip_w_q    <= '0;
      clip_h_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cabp_pkg::RegChannelLayout: layout_q    <= cfg_data_i[8:0];
        cabp_pkg::RegPickMode:      pick_q      <= cfg_data_i[0];
        cabp_pkg::RegClipEnable:    clip_en_q   <= cfg_data_i[0];
        cabp_pkg::RegClipLeft:      clip_left_q <= cfg_data_i;
        cabp_pkg::RegClipTop:       clip_top_q  <= cfg_data_i;
        cabp_pkg::RegClipWidth:     clip_w_q    <= cfg_data_i[14:0];
        cabp_pkg::RegClipHeight:    clip_h_q    <= cfg_data_i[14:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: a stage loads when it is empty or its beat moves on.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: clip test, pick the operation, unpack destination bytes
  // ---------------------------------------------------------------------------
  logic signed [16:0] right_edge, bottom_edge;
  logic               in_clip;
  cabp_pkg::op_e      op_d;

  // Far edges in 17 bits so the sum never wraps.
  assign right_edge  = 17'(clip_left_q) + $signed({2'b00, clip_w_q});
  assign bottom_edge = 17'(clip_top_q) + $signed({2'b00, clip_h_q});

  assign in_clip = !clip_en_q ||
                   ((pixel_x_i >= clip_left_q) && (17'(pixel_x_i) < right_edge) &&
                    (pixel_y_i >= clip_top_q)  && (17'(pixel_y_i) < bottom_edge));

  always_comb begin
    if (!in_clip) begin
      op_d = cabp_pkg::OpKeep;
    end else if (color_null_i) begin
      op_d = cabp_pkg::OpClear;
    end else if (!pick_q && blend_enable_i) begin
      op_d = cabp_pkg::OpBlend;
    end else begin
      op_d = cabp_pkg::OpCopy;
    end
  end

  cabp_pkg::op_e op1_q;
  logic [7:0]    sr1_q, sg1_q, sb1_q, sa1_q;
  logic [7:0]    dr1_q, dg1_q, db1_q, da1_q;
  logic [31:0]   dst1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q  <= op_d;
      sr1_q  <= src_red_i;
      sg1_q  <= src_green_i;
      sb1_q  <= src_blue_i;
      sa1_q  <= src_alpha_i;
      dr1_q  <= cabp_pkg::get_slot(dest_word_i, layout_q[1:0]);
      dg1_q  <= cabp_pkg::get_slot(dest_word_i, layout_q[3:2]);
      db1_q  <= cabp_pkg::get_slot(dest_word_i, layout_q[5:4]);
      // no alpha byte: destination alpha reads as opaque
      da1_q  <= layout_q[8] ? cabp_pkg::get_slot(dest_word_i, layout_q[7:6])
                            : cabp_pkg::ByteMax;
      dst1_q <= dest_word_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: weighted sums a*s + (255-a)*d per color channel
  // ---------------------------------------------------------------------------
  logic [7:0]  inv_a;
  logic [16:0] sum_r, sum_g, sum_b;

  assign inv_a = cabp_pkg::ByteMax - sa1_q;
  assign sum_r = 17'(sa1_q * sr1_q) + 17'(inv_a * dr1_q);
  assign sum_g = 17'(sa1_q * sg1_q) + 17'(inv_a * dg1_q);
  assign sum_b = 17'(sa1_q * sb1_q) + 17'(inv_a * db1_q);

  cabp_pkg::op_e op2_q;
  logic [15:0]   pr2_q, pg2_q, pb2_q;
  logic [7:0]    sr2_q, sg2_q, sb2_q, sa2_q, da2_q;
  logic [31:0]   dst2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      op2_q  <= op1_q;
      // sums are at most 255*255, so 16 bits hold them
      pr2_q  <= sum_r[15:0];
      pg2_q  <= sum_g[15:0];
      pb2_q  <= sum_b[15:0];
      sr2_q  <= sr1_q;
      sg2_q  <= sg1_q;
      sb2_q  <= sb1_q;
      sa2_q  <= sa1_q;
      da2_q  <= da1_q;
      dst2_q <= dst1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by 255, repack, select the result word
  // ---------------------------------------------------------------------------
  logic [31:0] word_d;

  always_comb begin
    case (op2_q)
      cabp_pkg::OpKeep:  word_d = dst2_q;
      cabp_pkg::OpClear: word_d = '0;
      cabp_pkg::OpBlend: word_d = cabp_pkg::pack_px(layout_q, cabp_pkg::div255(pr2_q),
                                                    cabp_pkg::div255(pg2_q),
                                                    cabp_pkg::div255(pb2_q), da2_q);
      default:           word_d = cabp_pkg::pack_px(layout_q, sr2_q, sg2_q, sb2_q, sa2_q);
    endcase
  end

  logic        done3_q;
  logic [31:0] word3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      done3_q <= (op2_q != cabp_pkg::OpKeep);
      word3_q <= word_d;
    end
  end

  assign out_valid_o  = v3_q;
  assign write_done_o = done3_q;
  assign pixel_out_o  = word3_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Input stalls only with every stage full and the output held.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  // A beat taken at the output with another in stage 2 leaves the output valid.
  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && v2_q) |=> out_valid_o)
    else $error("beat in stage 2 lost after output handoff");

  // Output becomes valid only from a beat that sat in stage 2.
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v3_q) |-> $past(v2_q))
    else $error("output valid without a beat in stage 2");

  // A stage 1 beat is never dropped while stage 2 is held.
  a_hold1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> v1_q)
    else $error("stage 1 beat dropped under stall");

endmodule

`default_nettype wire

FILE: bench/clipped_alpha_blend_pixel_test.sv
// Self-checking bench for the clipped alpha blend pixel block: directed and random pixel writes.
module clipped_alpha_blend_pixel_test;

  // One pixel write as offered on the input channel.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic               no_color;
    logic               blend;
    logic [31:0]        dst;
  } pixel_beat_t;

  // What the block should return for one pixel write.
  typedef struct {
    logic        done;
    logic [31:0] word;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [cabp_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [cabp_pkg::CfgDataW-1:0] cfg_data = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [7:0]         src_red;
  logic [7:0]         src_green;
  logic [7:0]         src_blue;
  logic [7:0]         src_alpha;
  logic               color_null;
  logic               blend_enable;
  logic [31:0]        dest_word;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        write_done;
  logic [31:0] pixel_out;

  // Bench copy of the register file, updated as each write completes.
  logic [8:0]         layout = cabp_pkg::LayoutReset;
  logic               pick_on = 1'b0;
  logic               clip_on = 1'b0;
  logic signed [15:0] clip_l = '0;
  logic signed [15:0] clip_t = '0;
  logic [14:0]        clip_w = '0;
  logic [14:0]        clip_h = '0;

  pixel_beat_t   pending_px[$];
  pixel_result_t expected_px[$];
  pixel_beat_t   offered = '{default: '0};

  logic beat_taken = 1'b0;
  int   gap_left = 0;
  int   hold_left = 0;
  bit   gaps_on = 1'b1;
  bit   stalls_on = 1'b1;
  int   long_holds_asked = 0;
  int   long_holds_given = 0;
  int   mismatches = 0;

  clipped_alpha_blend_pixel dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pixel_x_i      (pixel_x),
    .pixel_y_i      (pixel_y),
    .src_red_i      (src_red),
    .src_green_i    (src_green),
    .src_blue_i     (src_blue),
    .src_alpha_i    (src_alpha),
    .color_null_i   (color_null),
    .blend_enable_i (blend_enable),
    .dest_word_i    (dest_word),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .write_done_o   (write_done),
    .pixel_out_o    (pixel_out)
  );

  // The payload ports follow the offered beat; it only changes at a falling edge.
  assign pixel_x      = offered.x;
  assign pixel_y      = offered.y;
  assign src_red      = offered.red;
  assign src_green    = offered.green;
  assign src_blue     = offered.blue;
  assign src_alpha    = offered.alpha;
  assign color_null   = offered.no_color;
  assign blend_enable = offered.blend;
  assign dest_word    = offered.dst;

  initial forever #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Byte found at a two-bit slot of a packed word.
  function automatic logic [7:0] slot_byte(logic [31:0] w, logic [1:0] s);
    logic [31:0] t;
    t = w >> (8 * s);
    return t[7:0];
  endfunction

  // Lay the channels into a word by the current layout; shared slots OR together,
  // and alpha only lands when the layout says an alpha byte exists.
  function automatic logic [31:0] pack_word(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic [7:0] a);
    logic [31:0] w;
    w = (32'(r) << (8 * layout[1:0])) | (32'(g) << (8 * layout[3:2]))
      | (32'(b) << (8 * layout[5:4]));
    if (layout[8]) begin
      w = w | (32'(a) << (8 * layout[7:6]));
    end
    return w;
  endfunction

  // Source-over mix of one channel, truncated.
  function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] s, logic [7:0] d);
    int acc;
    acc = (int'(a) * int'(s) + (255 - int'(a)) * int'(d)) / 255;
    return acc[7:0];
  endfunction

  function automatic pixel_result_t blend_pixel(pixel_beat_t b);
    pixel_result_t res;
    int x, y, lo_x, lo_y, w, h;
    logic [7:0] keep_alpha;
    x = b.x;
    y = b.y;
    lo_x = clip_l;
    lo_y = clip_t;
    w = clip_w;
    h = clip_h;
    res.word = b.dst;
    // Far edges are exclusive; sums are plain int so nothing wraps.
    res.done = !clip_on || (x >= lo_x && x < lo_x + w && y >= lo_y && y < lo_y + h);
    if (res.done) begin
      if (b.no_color) begin
        res.word = '0;
      end else if (!pick_on && b.blend) begin
        // Without an alpha byte the destination reads as fully opaque.
        keep_alpha = layout[8] ? slot_byte(b.dst, layout[7:6]) : 8'hff;
        res.word = pack_word(mix_channel(b.alpha, b.red, slot_byte(b.dst, layout[1:0])),
                             mix_channel(b.alpha, b.green, slot_byte(b.dst, layout[3:2])),
                             mix_channel(b.alpha, b.blue, slot_byte(b.dst, layout[5:4])),
                             keep_alpha);
      end else begin
        res.word = pack_word(b.red, b.green, b.blue, b.alpha);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver and checker
  // ---------------------------------------------------------------------------

  // Idle stretch length, drawn from three ranges; the longest is picked least often.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch on %s: got %h, want %h at %0t", what, got, want, $time);
  endtask

  // Sender: hold a stalled beat, otherwise idle out the gap or offer the next beat.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !beat_taken) begin
        in_valid <= 1'b1;
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_px.size() != 0) begin
        offered <= pending_px.pop_front();
        in_valid <= 1'b1;
        gap_left <= (gaps_on && $urandom_range(0, 99) < 35) ? idle_span() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_holds_asked != long_holds_given) begin
      out_stall <= 1'b1;
      hold_left <= 80;
      long_holds_given <= long_holds_given + 1;
    end else if (stalls_on && $urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      hold_left <= idle_span() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Checker: compare the result beat first, then predict any beat taken at this edge.
  always @(posedge clk) begin : scoreboard
    pixel_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_px.size() == 0) begin
          report_mismatch("unexpected result", pixel_out, '0);
        end else begin
          want = expected_px.pop_front();
          if (write_done !== want.done) begin
            report_mismatch("write_done", 32'(write_done), 32'(want.done));
          end
          if (pixel_out !== want.word) begin
            report_mismatch("pixel_out", pixel_out, want.word);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_px.push_back(blend_pixel(offered));
      end
    end
    beat_taken <= in_valid && !in_stall;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic write_reg(logic [cabp_pkg::CfgIdxW-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      cabp_pkg::RegChannelLayout: layout = value[8:0];
      cabp_pkg::RegPickMode:      pick_on = value[0];
      cabp_pkg::RegClipEnable:    clip_on = value[0];
      cabp_pkg::RegClipLeft:      clip_l = value[15:0];
      cabp_pkg::RegClipTop:       clip_t = value[15:0];
      cabp_pkg::RegClipWidth:     clip_w = value[14:0];
      cabp_pkg::RegClipHeight:    clip_h = value[14:0];
      default:                    ;
    endcase
  endtask

  task automatic queue_pixel(int x, int y, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] a, logic no_color, logic blend, logic [31:0] dst);
    pixel_beat_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    p.no_color = no_color;
    p.blend = blend;
    p.dst = dst;
    pending_px.push_back(p);
  endtask

  // Wait until every beat is out and checked, then let the pipeline go quiet.
  task automatic settle();
    while (pending_px.size() != 0 || in_valid || expected_px.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic int corner_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r == 2) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 400)) - 200;
  endfunction

  function automatic int span_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 32767;
    if (r == 2) return $urandom_range(0, 32767);
    return $urandom_range(1, 40);
  endfunction

  // Coordinate near either edge of a clip span, anywhere, or at the range ends.
  function automatic int coord_near(int lo, int span);
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      v = ($urandom_range(0, 1) ? lo : lo + span) + int'($urandom_range(0, 8)) - 4;
    end else if (r < 8) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      v = (r == 8) ? -32768 : 32767;
    end
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  task automatic shuffle_settings();
    int r;
    logic [8:0] lay;
    r = $urandom_range(0, 5);
    case (r)
      0:       lay = 9'd0;
      1:       lay = 9'd511;
      2:       lay = cabp_pkg::LayoutReset;
      3:       lay = 9'h1e4;
      default: lay = $urandom_range(0, 511);
    endcase
    write_reg(cabp_pkg::RegChannelLayout, lay);
    write_reg(cabp_pkg::RegPickMode, $urandom_range(0, 3) == 0);
    write_reg(cabp_pkg::RegClipEnable, $urandom_range(0, 2) != 0);
    write_reg(cabp_pkg::RegClipLeft, corner_value());
    write_reg(cabp_pkg::RegClipTop, corner_value());
    write_reg(cabp_pkg::RegClipWidth, span_value());
    write_reg(cabp_pkg::RegClipHeight, span_value());
  endtask

  task automatic queue_random_pixel();
    int r;
    logic [7:0] a;
    r = $urandom_range(0, 4);
    a = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom);
    queue_pixel(coord_near(clip_l, clip_w), coord_near(clip_t, clip_h),
                8'($urandom), 8'($urandom), 8'($urandom), a,
                $urandom_range(0, 9) == 0, $urandom_range(0, 2) != 0, $urandom);
  endtask

  initial begin
    int phase;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: standard layout without alpha byte, clip off.
    queue_pixel(0, 0, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 1'b1, 32'hffffffff); // clear
    queue_pixel(-32768, -32768, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 32'h0); // opaque
    queue_pixel(32767, 32767, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 32'hffffffff);
    queue_pixel(1, -1, 8'h80, 8'h40, 8'hc0, 8'h80, 1'b0, 1'b1, 32'h12345678);
    queue_pixel(5, 5, 8'haa, 8'h55, 8'hf0, 8'h0f, 1'b0, 1'b0, 32'h87654321); // copy
    queue_pixel(-1, 1, 8'hff, 8'h00, 8'hff, 8'h01, 1'b0, 1'b1, 32'ha5a5a5a5);
    settle();

    // Alpha byte present: destination alpha must survive a blend.
    write_reg(cabp_pkg::RegChannelLayout, 9'h1e4);
    queue_pixel(3, 4, 8'h10, 8'h20, 8'h30, 8'h7f, 1'b0, 1'b1, 32'hdeadbeef);
    queue_pixel(3, 4, 8'h10, 8'h20, 8'h30, 8'h7f, 1'b0, 1'b0, 32'hdeadbeef);
    settle();
    // Every channel in slot zero, no alpha: bytes OR together.
    write_reg(cabp_pkg::RegChannelLayout, 0);
    queue_pixel(0, 0, 8'h81, 8'h42, 8'h24, 8'hff, 1'b0, 1'b0, 32'h5a5a5a5a);
    queue_pixel(0, 0, 8'h81, 8'h42, 8'h24, 8'h90, 1'b0, 1'b1, 32'h5a5a5a5a);
    settle();
    // Every channel and alpha in the top slot.
    write_reg(cabp_pkg::RegChannelLayout, 511);
    queue_pixel(0, 0, 8'h0f, 8'hf0, 8'h33, 8'h40, 1'b0, 1'b1, 32'hc3000000);
    queue_pixel(0, 0, 8'h0f, 8'hf0, 8'h33, 8'h40, 1'b0, 1'b0, 32'hc3000000);
    settle();

    // Small clip rectangle: probe just inside and just outside each edge.
    write_reg(cabp_pkg::RegChannelLayout, cabp_pkg::LayoutReset);
    write_reg(cabp_pkg::RegClipEnable, 1);
    write_reg(cabp_pkg::RegClipLeft, 10);
    write_reg(cabp_pkg::RegClipTop, -5);
    write_reg(cabp_pkg::RegClipWidth, 4);
    write_reg(cabp_pkg::RegClipHeight, 3);
    queue_pixel(9, -4, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 32'h01020304);
    queue_pixel(10, -5, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 32'h01020304);
    queue_pixel(13, -3, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b0, 32'h01020304);
    queue_pixel(14, -4, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b0, 32'h01020304);
    queue_pixel(11, -6, 8'h11, 8'h22, 8'h33, 8'h44, 1'b1, 1'b0, 32'h01020304);
    queue_pixel(11, -2, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 32'h01020304);
    settle();

    // Zero width rejects everything; then a huge rectangle at the range corners.
    write_reg(cabp_pkg::RegPickMode, 1);
    write_reg(cabp_pkg::RegClipWidth, 0);
    queue_pixel(10, -5, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 32'hcafef00d);
    settle();
    write_reg(cabp_pkg::RegClipLeft, 32760);
    write_reg(cabp_pkg::RegClipTop, -32768);
    write_reg(cabp_pkg::RegClipWidth, 32767);
    write_reg(cabp_pkg::RegClipHeight, 32767);
    queue_pixel(32767, -32768, 8'h9c, 8'h6b, 8'h3e, 8'h20, 1'b0, 1'b1, 32'h00ff00ff);
    queue_pixel(32759, -32768, 8'h9c, 8'h6b, 8'h3e, 8'h20, 1'b0, 1'b1, 32'h00ff00ff);
    queue_pixel(0, 0, 8'h9c, 8'h6b, 8'h3e, 8'h20, 1'b1, 1'b1, 32'h00ff00ff);
    settle();

    // Random phases, each under fresh settings. Every third phase runs without
    // idling on either side; phase two leans on the receiver to back up the pipe.
    for (phase = 0; phase < 9; phase++) begin
      shuffle_settings();
      gaps_on = (phase % 3) != 0;
      stalls_on = (phase % 3) != 0;
      if (phase == 2) begin
        gaps_on = 1'b0;
        stalls_on = 1'b1;
        long_holds_asked++;
      end
      repeat (200) queue_random_pixel();
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop in case the pipe hangs or a result never shows up.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
